[rtl/ogmr_pkg.sv]
// Package with shared types, constants and point helpers for the octant group merge core.
package ogmr_pkg;

  // Store geometry and field widths.
  localparam int MaxEntries = 64;
  localparam int CoordBits  = 16;
  localparam int AddrW      = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int FieldW     = 16;
  localparam int PointW     = 4 * FieldW;
  localparam int KeyW       = 4 * FieldW;
  localparam int LevelW     = 4;
  localparam int PosW       = 6;
  localparam int NumGroups  = 4;
  localparam int GrpW       = 2;

  // One input transaction.
  typedef struct packed {
    logic [FieldW-1:0] batch_id;
    logic [FieldW-1:0] x_coord;
    logic [FieldW-1:0] y_coord;
    logic [FieldW-1:0] z_coord;
    logic              last_point;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic [PosW-1:0] position;
    logic            last_result;
  } out_item_t;

  // A group head competing in the merge.
  typedef struct packed {
    logic            vld;
    logic [KeyW-1:0] key;
    logic [GrpW-1:0] grp;
  } cand_t;

  // Keep only the low CoordBits bits of a coordinate.
  function automatic logic [FieldW-1:0] coord_mask(input logic [FieldW-1:0] v);
    logic [FieldW-1:0] m;
    m = FieldW'((32'd1 << CoordBits) - 32'd1);
    return v & m;
  endfunction

  // Pack an input item into a stored point: batch | x | y | z.
  function automatic logic [PointW-1:0] pack_point(input in_item_t it);
    return {it.batch_id, coord_mask(it.x_coord), coord_mask(it.y_coord),
            coord_mask(it.z_coord)};
  endfunction

  // Group from bit level of x (upper bit) and bit level of y (lower bit).
  function automatic logic [GrpW-1:0] group_of(input logic [PointW-1:0] p,
                                               input logic [LevelW-1:0] lvl);
    logic [FieldW-1:0] x;
    logic [FieldW-1:0] y;
    x = p[3*FieldW-1:2*FieldW];
    y = p[2*FieldW-1:FieldW];
    return {x[lvl], y[lvl]};
  endfunction

  // Merge key: batch, then coordinates shifted right by level plus one.
  function automatic logic [KeyW-1:0] key_of(input logic [PointW-1:0] p,
                                             input logic [LevelW-1:0] lvl);
    logic [LevelW:0] s;
    s = {1'b0, lvl} + (LevelW+1)'(1);
    return {p[4*FieldW-1:3*FieldW],
            p[3*FieldW-1:2*FieldW] >> s,
            p[2*FieldW-1:FieldW] >> s,
            p[FieldW-1:0] >> s};
  endfunction

endpackage

[rtl/ogmr_pick.sv]
// Two-way selection of the smaller valid merge key, the lower group winning ties.
module ogmr_pick (
  input  ogmr_pkg::cand_t lo_i,
  input  ogmr_pkg::cand_t hi_i,
  output ogmr_pkg::cand_t win_o
);

  // The lower candidate wins when valid and not larger than the upper one.
  always_comb begin
    if (lo_i.vld && (!hi_i.vld || (lo_i.key <= hi_i.key))) begin
      win_o = lo_i;
    end else begin
      win_o = hi_i;
    end
  end

endmodule

[rtl/octant_group_merge_reorder_core.sv]
// Top level of the octant group merge core: point store, group link scan and four-way merge.
//
// Channel  | Direction | Handshake                      | Payload
// item     | in        | start_i high while busy_o low  | item_i (in_item_t)
// result   | out       | result_valid_o, one cycle each | result_o (out_item_t)
// config   | in        | cfg_valid_i and cfg_ready_o    | cfg_data_i (layer level)
//
// Points load at one per cycle; busy_o stays low between loads.
// The last point starts a scan over the store that links each group in a second
// memory, one store read per cycle. Each position is then selected in two compare
// stages; when its group has a further member, a link read and a store read follow.
// A closing state ends the merge. Reset needs no clearing pass. Results cannot be stalled.
module octant_group_merge_reorder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  ogmr_pkg::in_item_t                item_i,
  output logic                              result_valid_o,
  output ogmr_pkg::out_item_t               result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ogmr_pkg::LevelW-1:0]       cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP1,
    ST_CMP2,
    ST_LINK,
    ST_FETCH,
    ST_DONE
  } state_e;

  state_e                             state_q;
  logic [ogmr_pkg::CntW-1:0]          count_q;
  logic [ogmr_pkg::CntW-1:0]          scan_q;
  logic [ogmr_pkg::CntW-1:0]          emit_q;
  logic [ogmr_pkg::LevelW-1:0]        level_q;
  logic                               pv_q;
  logic [ogmr_pkg::AddrW-1:0]         pidx_q;
  logic [ogmr_pkg::NumGroups-1:0]     hval_q;
  logic [ogmr_pkg::AddrW-1:0]         hpos_q [ogmr_pkg::NumGroups];
  logic [ogmr_pkg::AddrW-1:0]         tail_q [ogmr_pkg::NumGroups];
  logic [ogmr_pkg::KeyW-1:0]          hkey_q [ogmr_pkg::NumGroups];
  ogmr_pkg::cand_t                    w01_q;
  ogmr_pkg::cand_t                    w23_q;
  logic [ogmr_pkg::GrpW-1:0]          best_q;
  logic                               res_valid_q;
  ogmr_pkg::out_item_t                res_q;

  // Point store and group link memory, both with registered read data.
  logic [ogmr_pkg::PointW-1:0]        pmem [ogmr_pkg::MaxEntries];
  logic [ogmr_pkg::PointW-1:0]        pr_q;
  logic [ogmr_pkg::AddrW-1:0]         lmem [ogmr_pkg::MaxEntries];
  logic [ogmr_pkg::AddrW-1:0]         lr_q;

  logic                               accept;
  logic                               pm_we;
  logic [ogmr_pkg::AddrW-1:0]         pm_raddr;
  logic                               lm_we;
  logic [ogmr_pkg::AddrW-1:0]         lm_raddr;
  logic [ogmr_pkg::GrpW-1:0]          scan_grp;
  logic [ogmr_pkg::GrpW-1:0]          tsel;
  logic [ogmr_pkg::AddrW-1:0]         tail_sel;
  logic [ogmr_pkg::AddrW-1:0]         win_pos;
  logic                               win_last;
  ogmr_pkg::cand_t                    cand [ogmr_pkg::NumGroups];
  ogmr_pkg::cand_t                    w01;
  ogmr_pkg::cand_t                    w23;
  ogmr_pkg::cand_t                    win;

  assign accept         = start_i && (state_q == ST_IDLE);
  assign busy_o         = (state_q != ST_IDLE);
  assign cfg_ready_o    = (state_q == ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // Candidates built from the current group heads.
  always_comb begin
    for (int g = 0; g < ogmr_pkg::NumGroups; g++) begin
      cand[g].vld = hval_q[g];
      cand[g].key = hkey_q[g];
      cand[g].grp = ogmr_pkg::GrpW'(g);
    end
  end

  // First tournament stage pairs groups 0/1 and 2/3; the second picks the overall winner.
  ogmr_pick u_pick01 (.lo_i(cand[0]), .hi_i(cand[1]), .win_o(w01));
  ogmr_pick u_pick23 (.lo_i(cand[2]), .hi_i(cand[3]), .win_o(w23));
  ogmr_pick u_pickfn (.lo_i(w01_q),   .hi_i(w23_q),   .win_o(win));

  // Group of the point returned by the scan, and one shared read of the tail table.
  assign scan_grp = ogmr_pkg::group_of(pr_q, level_q);
  assign tsel     = (state_q == ST_SCAN) ? scan_grp : win.grp;
  assign tail_sel = tail_q[tsel];
  assign win_pos  = hpos_q[win.grp];
  assign win_last = ((emit_q + ogmr_pkg::CntW'(1)) == count_q);

  // Memory control.
  assign pm_we    = accept && (count_q < ogmr_pkg::CntW'(ogmr_pkg::MaxEntries));
  assign lm_we    = (state_q == ST_SCAN) && pv_q && hval_q[scan_grp];
  assign lm_raddr = win_pos;

  always_comb begin
    case (state_q)
      ST_SCAN: pm_raddr = scan_q[ogmr_pkg::AddrW-1:0];
      ST_LINK: pm_raddr = lr_q;
      default: pm_raddr = lr_q;
    endcase
  end

  // Point store: written while loading, read during scan and head refill.
  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pmem[count_q[ogmr_pkg::AddrW-1:0]] <= ogmr_pkg::pack_point(item_i);
    end
    pr_q <= pmem[pm_raddr];
  end

  // Link memory: next member of the same group, written behind each group's tail.
  always_ff @(posedge clk_i) begin
    if (lm_we) begin
      lmem[tail_sel] <= pidx_q;
    end
    lr_q <= lmem[lm_raddr];
  end

  // Control sequencer with the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      emit_q      <= '0;
      level_q     <= '0;
      pv_q        <= 1'b0;
      hval_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        level_q <= cfg_data_i;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (pm_we) begin
              count_q <= count_q + ogmr_pkg::CntW'(1);
            end
            if (item_i.last_point) begin
              scan_q  <= '0;
              pv_q    <= 1'b0;
              hval_q  <= '0;
              emit_q  <= '0;
              state_q <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          // Issue one store read per cycle until every point was seen.
          if (scan_q < count_q) begin
            pv_q   <= 1'b1;
            pidx_q <= scan_q[ogmr_pkg::AddrW-1:0];
            scan_q <= scan_q + ogmr_pkg::CntW'(1);
          end else begin
            pv_q <= 1'b0;
          end
          // The first member of a group becomes its head; every member its new tail.
          if (pv_q) begin
            if (!hval_q[scan_grp]) begin
              hval_q[scan_grp] <= 1'b1;
              hpos_q[scan_grp] <= pidx_q;
              hkey_q[scan_grp] <= ogmr_pkg::key_of(pr_q, level_q);
            end
            tail_q[scan_grp] <= pidx_q;
          end
          if ((scan_q == count_q) && !pv_q) begin
            state_q <= ST_CMP1;
          end
        end

        ST_CMP1: begin
          w01_q   <= w01;
          w23_q   <= w23;
          state_q <= ST_CMP2;
        end

        ST_CMP2: begin
          if (!win.vld) begin
            state_q <= ST_DONE;
          end else begin
            res_valid_q          <= 1'b1;
            res_q.position       <= ogmr_pkg::PosW'(win_pos);
            res_q.last_result    <= win_last;
            emit_q               <= emit_q + ogmr_pkg::CntW'(1);
            best_q               <= win.grp;
            if (win_pos == tail_sel) begin
              hval_q[win.grp] <= 1'b0;
              state_q         <= win_last ? ST_DONE : ST_CMP1;
            end else begin
              state_q <= win_last ? ST_DONE : ST_LINK;
            end
          end
        end

        ST_LINK: begin
          // Link data is in; the store read of the next member goes out now.
          hpos_q[best_q] <= lr_q;
          state_q        <= ST_FETCH;
        end

        ST_FETCH: begin
          hkey_q[best_q] <= ogmr_pkg::key_of(pr_q, level_q);
          state_q        <= ST_CMP1;
        end

        ST_DONE: begin
          count_q <= '0;
          hval_q  <= '0;
          emit_q  <= '0;
          state_q <= ST_IDLE;
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/ogmr_checker.sv]
// Port-level checker for the octant group merge core and its bind statement.
module ogmr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input ogmr_pkg::in_item_t          item_i,
  input logic                        result_valid_o,
  input ogmr_pkg::out_item_t         result_o,
  input logic                        cfg_ready_o
);

  // Results appear only while a merge is in progress.
  a_result_in_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result transaction outside a merge");

  // A transaction without the last mark leaves the core free for the next one.
  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !item_i.last_point) |=> !busy_o)
    else $error("load transaction made the core busy");

  // A transaction with the last mark starts the merge.
  a_last_starts_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.last_point) |=> busy_o)
    else $error("last transaction did not start a merge");

  // No result follows directly after the final result of a permutation.
  a_final_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last_result) |=> !result_valid_o)
    else $error("result transaction after the final one");

  // Configuration is never taken during a merge.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !busy_o)
    else $error("configuration ready while busy");

endmodule

bind octant_group_merge_reorder_core ogmr_checker u_ogmr_checker (.*);
